// ===== rtl/core/ddf_pkg.sv =====
// shared types and constants for the dle stx/etx deframer
package ddf_pkg;

  localparam logic [7:0] DLE_CODE = 8'h10;
  localparam logic [7:0] ETX_CODE = 8'h03;

  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] MIN_LEN_RST    = 8'd4;

  localparam int CFG_ADDR_W = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_START_BYTE = 1'b0,
    REG_MIN_LEN    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_SHORT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_CHK  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       frame_end;
  } res_item_t;

endpackage

// ===== rtl/core/dle_stx_etx_deframer_core.sv =====
// dle stuffed stx/etx frame receiver with xor check byte, single module
//
// usage:
//   input channel (in_valid/in_stall/in_byte) takes one received byte per item.
//   bytes are ignored until the start byte; the frame body is then unescaped
//   and each payload byte leaves on the result channel as a data item
//   (out_kind = data, out_frame_end = 0); the byte after the unescaped etx is
//   the check byte and gives one status item (good, bad checksum or too short)
//   with out_frame_end = 1 and out_byte = 0. a lone dle gives two data items.
// throughput:
//   an accepted byte is held in the input register, decoded from it, and its results
//   are written into the result queue that drives the result port. one byte per
//   cycle while the receiver keeps up; a byte with two results leaves them one after
//   the other on the single-item result port.
// stall:
//   results collect in a four-entry queue; decoding holds while fewer than two
//   entries are free and in_stall then rises.
// reset:
//   rst_n (synchronous) empties the queue and input register, returns to
//   hunting and restores start byte 0x02 and minimum length 4.
// configuration: apb, start byte at 0x0, minimum frame length at 0x4.
module dle_stx_etx_deframer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic [1:0]                    out_kind,
  output logic                          out_frame_end,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ddf_pkg::*;

  // configuration registers
  logic [7:0] start_byte_r;
  logic [7:0] min_len_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  // input register
  logic       ir_vld_r;
  logic [7:0] ir_byte_r;

  // frame state
  phase_t     phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  // result queue
  res_item_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, wr_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic [FIFO_PTR_W-1:0]   wr_ptr1;
  logic [1:0]              push_n;
  res_item_t               push0, push1;
  logic                    pop;
  logic                    proc_go;
  logic                    in_acc;
  logic [8:0]              frame_len;
  res_item_t               head;

  // apb access, always ready
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    prdata = 32'd0;
    case (cfg_idx)
      REG_START_BYTE: prdata = {24'd0, start_byte_r};
      REG_MIN_LEN:    prdata = {24'd0, min_len_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      min_len_r    <= MIN_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_BYTE: start_byte_r <= pwdata[7:0];
        REG_MIN_LEN:    min_len_r    <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  // decode only when two queue entries are free, enough for any byte
  assign proc_go  = ir_vld_r & (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_stall = ir_vld_r & ~proc_go;
  assign in_acc   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_vld_r <= 1'b0;
    end else if (in_acc) begin
      ir_vld_r <= 1'b1;
    end else if (proc_go) begin
      ir_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ir_byte_r <= in_byte;
    end
  end

  // frame length counts start and check bytes on top of the escaped bytes
  assign frame_len = {1'b0, cnt_r} + 9'd2;

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    cnt_nxt   = cnt_r;
    push_n    = 2'd0;
    push0     = '{data: ir_byte_r, kind: KIND_DATA, frame_end: 1'b0};
    push1     = '{data: ir_byte_r, kind: KIND_DATA, frame_end: 1'b0};
    if (proc_go) begin
      case (phase_r)
        PH_HUNT: begin
          if (ir_byte_r == start_byte_r) begin
            phase_nxt = PH_BODY;
            xor_nxt   = 8'd0;
            cnt_nxt   = 8'd0;
          end
        end
        PH_BODY: begin
          xor_nxt = xor_r ^ ir_byte_r;
          cnt_nxt = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
          if (ir_byte_r == DLE_CODE) begin
            phase_nxt = PH_ESC;
          end else if (ir_byte_r == ETX_CODE) begin
            phase_nxt = PH_CHK;
          end else begin
            push_n = 2'd1;
          end
        end
        PH_ESC: begin
          xor_nxt   = xor_r ^ ir_byte_r;
          cnt_nxt   = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
          phase_nxt = PH_BODY;
          if (ir_byte_r == DLE_CODE || ir_byte_r == ETX_CODE) begin
            push_n = 2'd1;
          end else begin
            // lone dle is kept ahead of the byte
            push_n     = 2'd2;
            push0.data = DLE_CODE;
          end
        end
        PH_CHK: begin
          push_n          = 2'd1;
          push0.data      = 8'd0;
          push0.frame_end = 1'b1;
          if (frame_len < {1'b0, min_len_r}) begin
            push0.kind = KIND_SHORT;
          end else if (ir_byte_r != xor_r) begin
            push0.kind = KIND_BAD;
          end else begin
            push0.kind = KIND_GOOD;
          end
          phase_nxt = PH_HUNT;
          xor_nxt   = 8'd0;
          cnt_nxt   = 8'd0;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      xor_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result queue
  assign wr_ptr1 = wr_ptr_r + FIFO_PTR_W'(1);
  assign pop     = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      count_r <= count_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end
  end

  assign head          = fifo_r[rd_ptr_r];
  assign out_valid     = (count_r != '0);
  assign out_byte      = head.data;
  assign out_kind      = head.kind;
  assign out_frame_end = head.frame_end;

`ifndef SYNTH
  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // a status item carries a verdict and a zero byte
  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_byte == 8'd0 && out_kind != KIND_DATA))
    else $error("malformed status item");

  // an item that does not close a frame is always a payload item
  a_data_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_end) |-> (out_kind == KIND_DATA))
    else $error("data item with verdict kind");

  // the check byte returns the receiver to hunting with cleared state
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && phase_r == PH_CHK) |=> (phase_r == PH_HUNT && cnt_r == 8'd0 && xor_r == 8'd0))
    else $error("frame state not cleared after check byte");
`endif

endmodule

// ===== verif/tb_dle_stx_etx_deframer_core.sv =====
// self-checking testbench for the dle stx/etx deframer core
module tb_dle_stx_etx_deframer_core;
  import ddf_pkg::*;

  // run shape
  localparam int RANDOM_ITEMS = 120;    // frame bytes in the random part
  localparam int CALM_AFTER   = 80;     // no idling on either side beyond this
  localparam int DRAIN_CYCLES = 4;      // input register plus decode, with margin
  localparam int LONG_HOLD    = 80;     // receiver hold-off that fills the block
  localparam int QUIET_LIMIT  = 4000;   // cycles with no handshake before giving up

  // frame tracker: follows the deframer byte by byte and keeps the items due
  class frame_tracker;
    logic [7:0] start_byte;
    logic [7:0] min_len;
    phase_t     phase;
    logic [7:0] xor_acc;
    logic [7:0] esc_cnt;
    res_item_t  due_items[$];
    int         errors;

    function new();
      start_byte = START_BYTE_RST;
      min_len    = MIN_LEN_RST;
      phase      = PH_HUNT;
      xor_acc    = 8'h00;
      esc_cnt    = 8'h00;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [7:0] value);
      case (idx)
        REG_START_BYTE: start_byte = value;
        REG_MIN_LEN:    min_len = value;
        default: ;
      endcase
    endfunction

    function void absorb(logic [7:0] b);
      xor_acc = xor_acc ^ b;
      if (esc_cnt != 8'hff) esc_cnt = esc_cnt + 8'd1;
    endfunction

    function void due(logic [7:0] data, kind_t kind, logic frame_end);
      due_items.push_back(res_item_t'{data: data, kind: kind, frame_end: frame_end});
    endfunction

    // returns 1 when the byte belongs to a frame rather than line noise
    function bit take_byte(logic [7:0] b);
      bit    in_frame;
      int    total;
      kind_t verdict;
      in_frame = (phase != PH_HUNT) || (b == start_byte);
      case (phase)
        PH_HUNT: begin
          if (b == start_byte) begin
            phase   = PH_BODY;
            xor_acc = 8'h00;
            esc_cnt = 8'h00;
          end
        end
        PH_BODY: begin
          absorb(b);
          if (b == DLE_CODE) phase = PH_ESC;
          else if (b == ETX_CODE) phase = PH_CHK;
          else due(b, KIND_DATA, 1'b0);
        end
        PH_ESC: begin
          absorb(b);
          phase = PH_BODY;
          if (b == DLE_CODE || b == ETX_CODE) begin
            due(b, KIND_DATA, 1'b0);
          end else begin
            // lone dle is kept in front of the byte
            due(DLE_CODE, KIND_DATA, 1'b0);
            due(b, KIND_DATA, 1'b0);
          end
        end
        default: begin
          total = int'(esc_cnt) + 2;
          if (total < int'(min_len)) verdict = KIND_SHORT;
          else if (b != xor_acc) verdict = KIND_BAD;
          else verdict = KIND_GOOD;
          due(8'h00, verdict, 1'b1);
          phase   = PH_HUNT;
          xor_acc = 8'h00;
          esc_cnt = 8'h00;
        end
      endcase
      return in_frame;
    endfunction

    function void report(string what, logic [7:0] data, logic [1:0] kind, logic frame_end);
      if (errors < 10) $display("item mismatch: %s, got byte %h kind %0d end %0b",
                                what, data, kind, frame_end);
      errors++;
    endfunction

    function void check_item(logic [7:0] data, logic [1:0] kind, logic frame_end);
      res_item_t want;
      if (due_items.size() == 0) begin
        report("no item due", data, kind, frame_end);
        return;
      end
      want = due_items.pop_front();
      if (want.data !== data || want.kind !== kind_t'(kind) || want.frame_end !== frame_end)
        report($sformatf("expected byte %h kind %0d end %0b",
                         want.data, want.kind, want.frame_end), data, kind, frame_end);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_frame_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker board = new();

  int frame_items = 0;   // bytes that were part of a frame
  bit tx_gaps = 1'b1;    // sender may idle
  bit rx_gaps = 1'b1;    // receiver may stall
  bit calm = 1'b0;       // last stretch: no idling at all
  bit hold_out = 1'b0;   // asks the receiver for one long hold-off
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  dle_stx_etx_deframer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_kind(out_kind), .out_frame_end(out_frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // every accepted result goes straight to the tracker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_item(out_byte, out_kind, out_frame_end);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_gaps && !calm && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without any handshake means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one byte over the input channel; valid stays up for a back-to-back byte
  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (board.take_byte(b)) frame_items++;
  endtask

  // stop sending and wait until the block has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic cfg_write(input reg_idx_t idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == DLE_CODE || b == ETX_CODE);
    return b;
  endfunction

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // well-formed frame with random body, optionally a wrong check byte; an open one stops before etx
  task automatic send_frame(input int tokens, input bit corrupt, input bit leave_open);
    logic [7:0] chk;
    logic [7:0] b;
    chk = 8'h00;
    send_byte(board.start_byte);
    repeat (tokens) begin
      case ($urandom_range(0, 7))
        0: begin send_byte(DLE_CODE); send_byte(DLE_CODE); end
        1: begin send_byte(DLE_CODE); send_byte(ETX_CODE); chk ^= DLE_CODE ^ ETX_CODE; end
        2: begin
          b = plain_byte();
          send_byte(DLE_CODE);
          send_byte(b);
          chk ^= DLE_CODE ^ b;
        end
        default: begin
          b = plain_byte();
          send_byte(b);
          chk ^= b;
        end
      endcase
    end
    if (!leave_open) begin
      send_byte(ETX_CODE);
      chk ^= ETX_CODE;
      if (corrupt) chk ^= 8'($urandom_range(1, 255));
      send_byte(chk);
    end
  endtask

  initial begin : stimulus
    int         nframes;
    int         pick;
    logic [7:0] start_val;
    logic [7:0] len_val;
    logic [7:0] opening [14];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset settings: line noise, then a frame with
    // both escapes, a lone dle, the start byte as data and zero
    opening = '{8'hff, 8'h10, 8'h02, 8'h41, 8'h10, 8'h10, 8'h10, 8'h03, 8'h10, 8'hff,
                8'h02, 8'h00, 8'h03, 8'hbc};
    foreach (opening[i])
      send_byte(opening[i]);
    // too short with a right check byte, then too short with a wrong one
    send_byte(8'h02); send_byte(ETX_CODE); send_byte(8'h03);
    send_byte(8'h02); send_byte(ETX_CODE); send_byte(8'h55);
    // exactly the minimum length, wrong check byte
    send_byte(8'h02); send_byte(8'h7e); send_byte(ETX_CODE); send_byte(8'h00);

    // registers change while a frame is open; the body carries on
    send_byte(8'h02); send_byte(8'h5a);
    settle();
    cfg_write(REG_START_BYTE, DLE_CODE);
    cfg_write(REG_MIN_LEN, 8'd1);
    send_byte(ETX_CODE); send_byte(8'h59);

    // start byte equal to dle, minimum of one
    repeat (3) send_frame($urandom_range(0, 6), 1'($urandom_range(0, 1)), 1'b0);
    settle();

    // start byte equal to etx, minimum of zero: nothing is too short
    cfg_write(REG_START_BYTE, ETX_CODE);
    cfg_write(REG_MIN_LEN, 8'd0);
    send_frame(0, 1'b0, 1'b0);
    repeat (2) send_frame($urandom_range(0, 6), 1'($urandom_range(0, 1)), 1'b0);
    settle();

    // top of both ranges: a short frame, then one long enough to saturate
    // while the receiver holds off and the sender keeps offering
    cfg_write(REG_START_BYTE, 8'hff);
    cfg_write(REG_MIN_LEN, 8'd255);
    send_frame(0, 1'b0, 1'b0);
    tx_gaps  = 1'b0;
    hold_out = 1'b1;
    send_frame(200, 1'b0, 1'b0);
    tx_gaps  = 1'b1;
    send_frame(4, 1'b1, 1'b0);
    settle();
    cfg_write(REG_START_BYTE, 8'h00);
    cfg_write(REG_MIN_LEN, 8'd8);
    send_frame(3, 1'b0, 1'b0);

    // random phases: new settings each time, mostly well-formed frames
    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 5))
        0: start_val = 8'h00;
        1: start_val = 8'hff;
        2: start_val = DLE_CODE;
        3: start_val = ETX_CODE;
        4: start_val = START_BYTE_RST;
        default: start_val = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 7))
        0: len_val = 8'd1;
        1: len_val = 8'd255;
        2: len_val = 8'($urandom_range(2, 8));
        default: len_val = 8'($urandom_range(1, 20));
      endcase
      if ($urandom_range(0, 1)) cfg_write(REG_START_BYTE, start_val);
      cfg_write(REG_MIN_LEN, len_val);

      // some phases run flat out on one or both sides
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      calm = (frame_items > CALM_AFTER);

      nframes = $urandom_range(2, 8);
      repeat (nframes) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_noise($urandom_range(1, 10));
        else if (pick == 1) send_frame($urandom_range(0, 10), 1'b0, 1'b1);
        else if (pick == 2) send_frame($urandom_range(40, 90), 1'($urandom_range(0, 1)), 1'b0);
        else send_frame($urandom_range(0, 12), ($urandom_range(0, 4) == 0), 1'b0);
      end
    end

    // last stretch with no idling on either side
    calm = 1'b1;
    repeat (4) send_frame($urandom_range(0, 12), 1'b0, 1'b0);

    // drain: everything due must arrive, then a wait for stragglers
    settle();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ddf_pkg.sv
rtl/core/dle_stx_etx_deframer_core.sv
verif/tb_dle_stx_etx_deframer_core.sv
